@@ hdl/tcgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcgr_pkg: shared types and constants of the text console glyph renderer
// Operation codes, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int GLYPH_WIDTH = 8;
  localparam int PAIRS_PER_ROW = GLYPH_WIDTH / 2;

  localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [7:0] PAST_PRINTABLE  = 8'h7F;
  localparam logic [7:0] NEWLINE_CODE    = 8'h0A;
  localparam logic [6:0] FALLBACK_GLYPH  = 7'(PAST_PRINTABLE - FIRST_PRINTABLE);

  localparam logic [31:0] INK_RESET = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    OP_PRINT  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_HOME   = 2'd2,
    OP_UNUSED = 2'd3
  } tcgr_op_e;

  typedef enum logic [2:0] {
    REG_FRAME_BASE    = 3'd0,
    REG_LINE_PITCH    = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_INK_COLOR     = 3'd4,
    REG_PAPER_COLOR   = 3'd5
  } tcgr_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_SCALE,
    ST_BASE,
    ST_DRAW
  } tcgr_state_e;

  typedef struct packed {
    logic [47:0] frame_base;
    logic [15:0] line_pitch;
    logic [13:0] screen_width;
    logic [13:0] screen_height;
    logic [31:0] ink_color;
    logic [31:0] paper_color;
  } tcgr_cfg_t;

  typedef struct packed {
    logic font_wr;   // write one font row
    logic home;      // cursor to origin
    logic newline;   // advance a row
    logic capture;   // latch glyph of a printed character
    logic wrap;      // column overflow check before drawing
    logic scale;     // row pixel offset times pitch
    logic base;      // form first pixel address, bump column
    logic emit;      // produce one pixel pair
  } tcgr_cmd_t;

  typedef struct packed {
    logic is_newline;
    logic out_free;
    logic last_pair;
  } tcgr_sts_t;

endpackage

@@ hdl/tcgr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcgr_ctrl: sequencer of the glyph renderer
// Decodes accepted items and steps the datapath through setup and drawing.
// ----------------------------------------------------------------------------
module tcgr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          operation_i,
  output logic                in_stall_o,
  input  tcgr_pkg::tcgr_sts_t sts_i,
  output tcgr_pkg::tcgr_cmd_t cmd_o
);
  import tcgr_pkg::*;

  tcgr_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (tcgr_op_e'(operation_i))
            OP_LOAD:  cmd_o.font_wr = 1'b1;
            OP_HOME:  cmd_o.home = 1'b1;
            OP_PRINT: begin
              if (sts_i.is_newline) begin
                cmd_o.newline = 1'b1;
              end else begin
                cmd_o.capture = 1'b1;
                state_d = ST_WRAP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d = ST_DRAW;
      end
      ST_DRAW: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_pair) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/tcgr_dp.sv @@
// ----------------------------------------------------------------------------
// tcgr_dp: datapath of the glyph renderer
// Cursor, font memory, address generation and the result register.
// ----------------------------------------------------------------------------
module tcgr_dp #(
  parameter int GLYPH_COUNT  = 96,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcgr_pkg::tcgr_cfg_t cfg_i,
  input  tcgr_pkg::tcgr_cmd_t cmd_i,
  output tcgr_pkg::tcgr_sts_t sts_o,
  input  logic [7:0]          char_code_i,
  input  logic [6:0]          glyph_slot_i,
  input  logic [3:0]          glyph_line_i,
  input  logic [7:0]          glyph_bits_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [47:0]         pixel_address_o,
  output logic [31:0]         left_color_o,
  output logic [31:0]         right_color_o,
  output logic                last_o
);
  import tcgr_pkg::*;

  localparam int RW    = $clog2(GLYPH_HEIGHT);
  localparam int HW    = $clog2(GLYPH_HEIGHT + 1);
  localparam int AW    = $clog2(GLYPH_COUNT * GLYPH_HEIGHT);
  localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int YW    = 9 + HW;
  localparam int PW    = YW + 16;
  localparam int NW    = 10 + HW;

  // cursor
  logic [9:0] col_q;
  logic [8:0] row_q;
  logic [8:0] next_row;
  logic [13:0] col_end;
  logic        col_ovf;

  // font memory
  logic [7:0]    font_mem [DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;

  // drawing
  logic [6:0]    glyph_q;
  logic [6:0]    glyph_sel;
  logic [PW-1:0] prod_q;
  logic [14:0]   xoff_q;
  logic [YW-1:0] y_px;
  logic [47:0]   line_q;
  logic [RW-1:0] grow_q, grow_d;
  logic [1:0]    pair_q, pair_d;
  logic          last_pair;
  logic [7:0]    bits_sh;

  // result register
  logic        out_valid_q;
  logic [47:0] addr_q;
  logic [31:0] left_q, right_q;
  logic        last_q;

  // row advance with wrap to the top when the next row would not fit
  always_comb begin
    if ((NW'({1'b0, row_q} + 10'd2) * NW'(GLYPH_HEIGHT)) > NW'(cfg_i.screen_height)) begin
      next_row = '0;
    end else begin
      next_row = row_q + 9'd1;
    end
  end

  assign col_end = {11'({1'b0, col_q}) + 11'd1, 3'b000};
  assign col_ovf = col_end > cfg_i.screen_width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.home) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.newline || (cmd_i.wrap && col_ovf)) begin
      col_q <= '0;
      row_q <= next_row;
    end else if (cmd_i.base) begin
      col_q <= col_q + 10'd1;
    end
  end

  // printable codes map to their slot, everything else to the fallback glyph
  assign glyph_sel = (char_code_i >= FIRST_PRINTABLE && char_code_i < PAST_PRINTABLE) ?
                     7'(char_code_i - FIRST_PRINTABLE) : FALLBACK_GLYPH;

  assign y_px = YW'(row_q) * YW'(GLYPH_HEIGHT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      glyph_q <= glyph_sel;
    end
    if (cmd_i.scale) begin
      prod_q <= PW'(y_px) * PW'(cfg_i.line_pitch);
      xoff_q <= {col_q, 5'b00000};
    end
    if (cmd_i.base) begin
      line_q <= cfg_i.frame_base + 48'(prod_q) + 48'(xoff_q);
    end else if (cmd_i.emit && pair_q == 2'(PAIRS_PER_ROW - 1)) begin
      line_q <= line_q + 48'(cfg_i.line_pitch);
    end
  end

  assign last_pair = (grow_q == RW'(GLYPH_HEIGHT - 1)) && (pair_q == 2'(PAIRS_PER_ROW - 1));

  always_comb begin
    grow_d = grow_q;
    pair_d = pair_q;
    if (cmd_i.base) begin
      grow_d = '0;
      pair_d = '0;
    end else if (cmd_i.emit) begin
      pair_d = pair_q + 2'd1;
      if (pair_q == 2'(PAIRS_PER_ROW - 1)) begin
        grow_d = last_pair ? '0 : grow_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grow_q <= grow_d;
    pair_q <= pair_d;
  end

  // read follows the row shown next cycle, so rd_q always holds the current row
  assign rd_addr = AW'(glyph_q) * AW'(GLYPH_HEIGHT) + AW'(grow_d);
  assign wr_addr = AW'(glyph_slot_i) * AW'(GLYPH_HEIGHT) + AW'(glyph_line_i);
  assign wr_en   = cmd_i.font_wr && (32'(glyph_slot_i) < 32'(GLYPH_COUNT)) &&
                   (32'(glyph_line_i) < 32'(GLYPH_HEIGHT));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      font_mem[wr_addr] <= glyph_bits_i;
    end
    rd_q <= font_mem[rd_addr];
  end

  assign bits_sh = rd_q << {pair_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      addr_q  <= line_q + 48'({pair_q, 3'b000});
      left_q  <= bits_sh[7] ? cfg_i.ink_color : cfg_i.paper_color;
      right_q <= bits_sh[6] ? cfg_i.ink_color : cfg_i.paper_color;
      last_q  <= last_pair;
    end
  end

  assign sts_o.is_newline = (char_code_i == NEWLINE_CODE);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.last_pair  = last_pair;

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = addr_q;
  assign left_color_o    = left_q;
  assign right_color_o   = right_q;
  assign last_o          = last_q;

endmodule

@@ hdl/text_console_glyph_renderer.sv @@
// ----------------------------------------------------------------------------
// text_console_glyph_renderer: 8-pixel-wide text console drawing engine
// Turns character bytes into 32-bit pixel pair writes for a linear
// framebuffer, using a font loaded through the same input channel.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation. A font row load, a home and a
// newline finish in the cycle they are accepted and give no output. A printed
// character is accepted in idle, then passes the setup steps of row wrap
// check, pitch multiply and base address add, and then GLYPH_HEIGHT*4 pixel
// pairs follow, one pixel pair per cycle while the result register is not
// held by a stall. The pair rate is set by the result register and the
// single font memory read port, which fetches one glyph row ahead. The input
// opens again in the cycle after the last pair is loaded into the result
// register. Every glyph row must be loaded before a character using it is
// printed: the font memory has no reset. Configuration must be written
// through cfg_we_i / cfg_index_i / cfg_data_i only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer #(
  parameter int GLYPH_COUNT  = 96,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  char_code_i,
  input  logic [6:0]  glyph_slot_i,
  input  logic [3:0]  glyph_line_i,
  input  logic [7:0]  glyph_bits_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] pixel_address_o,
  output logic [31:0] left_color_o,
  output logic [31:0] right_color_o,
  output logic        last_o
);
  import tcgr_pkg::*;

  tcgr_cfg_t cfg_q;
  tcgr_cmd_t cmd;
  tcgr_sts_t sts;

  // configuration registers; writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ink_color: INK_RESET, default: '0};
    end else if (cfg_we_i) begin
      case (tcgr_reg_e'(cfg_index_i))
        REG_FRAME_BASE:    cfg_q.frame_base    <= cfg_data_i;
        REG_LINE_PITCH:    cfg_q.line_pitch    <= cfg_data_i[15:0];
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[13:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[13:0];
        REG_INK_COLOR:     cfg_q.ink_color     <= cfg_data_i[31:0];
        REG_PAPER_COLOR:   cfg_q.paper_color   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // sequencer: decodes transfers, walks setup and the pair loop
  tcgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // cursor, font memory, address math and result register
  tcgr_dp #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .char_code_i     (char_code_i),
    .glyph_slot_i    (glyph_slot_i),
    .glyph_line_i    (glyph_line_i),
    .glyph_bits_i    (glyph_bits_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_address_o (pixel_address_o),
    .left_color_o    (left_color_o),
    .right_color_o   (right_color_o),
    .last_o          (last_o)
  );

`ifndef SYNTHESIS
  // a pair is never produced over a result still held by a stall
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("pair emitted over stalled result");

  // after the final pair the input side opens again
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.last_pair) |=> (!in_stall_o && out_valid_o && last_o))
    else $error("no return to idle after final pair");

  // font writes happen only on an accepted transfer
  a_font_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.font_wr |-> (in_valid_i && !in_stall_o))
    else $error("font write without transfer");
`endif

endmodule

@@ sim/text_console_glyph_renderer_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_tb: self-checking regression for the renderer
// Loads every glyph that gets printed, then runs directed cursor and
// configuration cases and random traffic with random gaps on both channels.
// Every pixel pair is compared with the output of an in-bench shadow of the
// console state.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_tb;
  import tcgr_pkg::*;

  localparam int GLYPHS         = 96;
  localparam int ROWS           = 16;
  localparam int CLK_PERIOD     = 20;
  localparam int SETTLE_CYCLES  = 4;
  localparam int REPORT_LIMIT   = 10;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int LOADED_COUNT   = 8;

  // one pixel pair write as seen on the output channel
  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] left;
    logic [31:0] right;
    logic        last;
  } pixel_pair_t;

  // DUT-facing signals; every input has a known value from time zero
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  tcgr_reg_e   cfg_index   = REG_FRAME_BASE;
  logic [47:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  tcgr_op_e    operation   = OP_PRINT;
  logic [7:0]  char_code   = '0;
  logic [6:0]  glyph_slot  = '0;
  logic [3:0]  glyph_line  = '0;
  logic [7:0]  glyph_bits  = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [47:0] pixel_address;
  logic [31:0] left_color;
  logic [31:0] right_color;
  logic        pair_last;

  // shadow of the console: configuration, cursor and font
  tcgr_cfg_t   shadow_cfg;
  logic [9:0]  cursor_col;
  logic [8:0]  cursor_row;
  logic [7:0]  font_rows [GLYPHS*ROWS];

  pixel_pair_t expected_pairs [$];
  pixel_pair_t got_pair;
  pixel_pair_t want_pair;
  int          mismatch_count = 0;
  int          pair_wait      = 0;
  bit          tx_quiet       = 1'b0;  // sender never idles when set
  bit          rx_quiet       = 1'b0;  // receiver never stalls when set

  text_console_glyph_renderer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .char_code_i     (char_code),
    .glyph_slot_i    (glyph_slot),
    .glyph_line_i    (glyph_line),
    .glyph_bits_i    (glyph_bits),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .pixel_address_o (pixel_address),
    .left_color_o    (left_color),
    .right_color_o   (right_color),
    .last_o          (pair_last)
  );

  initial begin
    forever #(CLK_PERIOD/2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Codes the tests print
  // --------------------------------------------------------------------------

  // glyphs loaded in full; 0x7F stands for the fallback glyph
  function automatic logic [7:0] loaded_code(int k);
    case (k)
      0:       return 8'h20;
      1:       return 8'h21;
      2:       return 8'h30;
      3:       return 8'h41;
      4:       return 8'h42;
      5:       return 8'h5A;
      6:       return 8'h7E;
      default: return 8'h7F;
    endcase
  endfunction

  // a code outside the printable range that is not a newline
  function automatic logic [7:0] random_nonprintable();
    logic [7:0] code;
    code = 8'($urandom_range(128, 255));
    if ($urandom_range(0, 3) == 0) code = 8'($urandom_range(0, 31));
    if (code == NEWLINE_CODE) code = PAST_PRINTABLE;
    return code;
  endfunction

  // --------------------------------------------------------------------------
  // Shadow of the console
  // --------------------------------------------------------------------------

  // Cursor to the start of the next text row. The row falls back to 0 once the
  // following row would not fit; otherwise the 9-bit counter simply wraps.
  task automatic bump_cursor_row();
    int r;
    r = int'(cursor_row) + 1;
    cursor_col = '0;
    if ((r + 1) * ROWS > int'(shadow_cfg.screen_height)) r = 0;
    cursor_row = 9'(r);
  endtask

  // Applies one accepted transfer to the shadow and queues the pixel pairs
  // that a printed character produces, top row first, pairs left to right.
  task automatic predict_glyph_writes(tcgr_op_e op, logic [7:0] code,
                                      logic [6:0] slot, logic [3:0] line,
                                      logic [7:0] bits);
    logic [6:0]      glyph;
    logic [7:0]      row_bits;
    logic [63:0]     addr_full;
    longint unsigned px;
    longint unsigned py;
    pixel_pair_t     pair;
    int              r;
    int              c;
    case (op)
      OP_LOAD: begin
        // loads past the font size are dropped
        if (slot < GLYPHS && line < ROWS) font_rows[int'(slot) * ROWS + int'(line)] = bits;
      end
      OP_HOME: begin
        cursor_col = '0;
        cursor_row = '0;
      end
      OP_PRINT: begin
        if (code == NEWLINE_CODE) begin
          bump_cursor_row();
        end else begin
          // a cell that would cross the right edge moves to the next row first
          if ((longint'(cursor_col) + 1) * GLYPH_WIDTH > longint'(shadow_cfg.screen_width)) begin
            bump_cursor_row();
          end
          // anything outside the printable range shows the fallback glyph
          glyph = (code >= FIRST_PRINTABLE && code < PAST_PRINTABLE) ?
                  7'(code - FIRST_PRINTABLE) : FALLBACK_GLYPH;
          px = longint'(cursor_col) * GLYPH_WIDTH;
          py = longint'(cursor_row) * ROWS;
          for (r = 0; r < ROWS; r++) begin
            row_bits = font_rows[int'(glyph) * ROWS + r];
            for (c = 0; c < GLYPH_WIDTH; c += 2) begin
              // no clipping: cells off screen are drawn, address wraps at 2^48
              addr_full = 64'(shadow_cfg.frame_base)
                        + 64'(py + r) * 64'(shadow_cfg.line_pitch)
                        + 64'(px + c) * 64'd4;
              pair.addr  = addr_full[47:0];
              pair.left  = row_bits[GLYPH_WIDTH-1-c] ? shadow_cfg.ink_color
                                                      : shadow_cfg.paper_color;
              pair.right = row_bits[GLYPH_WIDTH-2-c] ? shadow_cfg.ink_color
                                                      : shadow_cfg.paper_color;
              pair.last  = (r == ROWS - 1) && (c == GLYPH_WIDTH - 2);
              expected_pairs.push_back(pair);
            end
          end
          // 10-bit column wraps on its own, row untouched
          cursor_col = cursor_col + 10'd1;
        end
      end
      default: ;  // unused operation code: no effect
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input channel and configuration port
  // --------------------------------------------------------------------------

  // One transfer on the input channel. Valid stays high into the next item
  // when no gap is drawn, so it is never dropped and raised in the same step.
  task automatic send_item(tcgr_op_e op, logic [7:0] code, logic [6:0] slot,
                           logic [3:0] line, logic [7:0] bits);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    char_code  <= code;
    glyph_slot <= slot;
    glyph_line <= line;
    glyph_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_glyph_writes(op, code, slot, line, bits);
  endtask

  // unused fields of each operation carry random values
  task automatic put_char(logic [7:0] code);
    send_item(OP_PRINT, code, 7'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic load_row(logic [6:0] slot, logic [3:0] line, logic [7:0] bits);
    send_item(OP_LOAD, 8'($urandom), slot, line, bits);
  endtask

  task automatic send_other(tcgr_op_e op);
    send_item(op, 8'($urandom), 7'($urandom), 4'($urandom), 8'($urandom));
  endtask

  // Hold off the sender until every queued pair is out; loads, homes and
  // newlines retire on acceptance, so the SETTLE_CYCLES wait covers them.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(tcgr_reg_e idx, logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_FRAME_BASE:    shadow_cfg.frame_base    = value;
      REG_LINE_PITCH:    shadow_cfg.line_pitch    = value[15:0];
      REG_SCREEN_WIDTH:  shadow_cfg.screen_width  = value[13:0];
      REG_SCREEN_HEIGHT: shadow_cfg.screen_height = value[13:0];
      REG_INK_COLOR:     shadow_cfg.ink_color     = value[31:0];
      REG_PAPER_COLOR:   shadow_cfg.paper_color   = value[31:0];
      default: ;
    endcase
  endtask

  // Reprogram the whole screen setup once the block is idle. Bits above each
  // register's width are random and must be dropped by the block.
  task automatic program_screen(logic [47:0] base, logic [15:0] pitch,
                                logic [13:0] width, logic [13:0] height,
                                logic [31:0] ink, logic [31:0] paper);
    wait_idle();
    write_reg(REG_FRAME_BASE, base);
    write_reg(REG_LINE_PITCH, {32'($urandom), pitch});
    write_reg(REG_SCREEN_WIDTH, {2'($urandom), 32'($urandom), width});
    write_reg(REG_SCREEN_HEIGHT, {2'($urandom), 32'($urandom), height});
    write_reg(REG_INK_COLOR, {16'($urandom), ink});
    write_reg(REG_PAPER_COLOR, {16'($urandom), paper});
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output channel: random stall per transfer, compare against the queue
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      pair_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_pair = '{pixel_address, left_color, right_color, pair_last};
        if (expected_pairs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected pixel pair: addr=%h left=%h right=%h last=%b",
                     got_pair.addr, got_pair.left, got_pair.right, got_pair.last);
        end else begin
          want_pair = expected_pairs.pop_front();
          if (got_pair !== want_pair) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("pixel pair mismatch: expected addr=%h left=%h right=%h last=%b, %s",
                       want_pair.addr, want_pair.left, want_pair.right, want_pair.last,
                       $sformatf("got addr=%h left=%h right=%h last=%b",
                                 got_pair.addr, got_pair.left, got_pair.right,
                                 got_pair.last));
          end
        end
        pair_wait = rx_quiet ? 0 : $urandom_range(0, 6);
      end else if (pair_wait != 0) begin
        pair_wait--;
      end
      out_stall <= (pair_wait != 0);
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every row of each glyph that gets printed is written first: the font
  // memory has no reset value.
  task automatic test_font_fill();
    for (int k = 0; k < LOADED_COUNT; k++) begin
      for (int l = 0; l < ROWS; l++) begin
        load_row(7'(loaded_code(k) - FIRST_PRINTABLE), 4'(l), 8'($urandom));
      end
    end
  endtask

  task automatic test_directed_cases();
    // reset setup: zero width and height keep the cell at the origin,
    // zero pitch and base, default ink
    put_char(8'h41);
    program_screen(48'hFFFF_FFFF_FF00, 16'd320, 14'd40, 14'd48,
                   32'h1234_5678, 32'h8765_4321);
    send_other(OP_HOME);
    // known rows in glyph 'B', then loads past the font that must be ignored
    load_row(7'd34, 4'd0, 8'hFF);
    load_row(7'd34, 4'd15, 8'h00);
    load_row(7'd34, 4'd7, 8'hA5);
    load_row(7'd96, 4'd3, 8'h00);
    load_row(7'd127, 4'd15, 8'hFF);
    // first and last printable, then nonprintable codes on both sides
    put_char(8'h20);
    put_char(8'h7E);
    put_char(8'h7F);
    put_char(8'h00);
    put_char(8'hFF);
    // row is full at five cells: this one wraps to the next row
    put_char(8'h42);
    put_char(NEWLINE_CODE);
    // second newline runs past the 48-pixel height and returns to row 0
    put_char(NEWLINE_CODE);
    put_char(8'h1F);
    send_other(OP_UNUSED);
    put_char(8'h42);
    send_other(OP_HOME);
    put_char(8'h80);
  endtask

  task automatic test_config_extremes();
    // everything zero: each character first advances a row that snaps back
    program_screen('0, '0, '0, '0, '0, 32'hFFFF_FFFF);
    put_char(8'h30);
    put_char(random_nonprintable());
    put_char(NEWLINE_CODE);
    put_char(8'h7E);
    // everything at its top value, address sum wraps past 2^48
    program_screen(48'hFFFF_FFFF_FFFF, 16'hFFFF, 14'h3FFF, 14'h3FFF,
                   32'hFFFF_FFFF, '0);
    send_other(OP_HOME);
    put_char(8'h21);
    put_char(8'h5A);
    put_char(NEWLINE_CODE);
    put_char(8'h0D);
    // a screen narrower than one glyph and shorter than one row
    program_screen(48'h0000_0000_1000, 16'd32768, 14'd7, 14'd15,
                   32'h00FF_00FF, 32'hFF00_FF00);
    put_char(8'h41);
    put_char(8'h5A);
  endtask

  // Random mix in several screen setups; small screens so wraps are common.
  task automatic test_random_traffic();
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      program_screen({16'($urandom), 32'($urandom)},
                     16'($urandom_range(0, 32768)),
                     14'($urandom_range(0, 80)),
                     14'($urandom_range(0, 96)),
                     $urandom, $urandom);
      // one phase without receiver stalls, one without sender gaps
      rx_quiet = (phase == 1);
      tx_quiet = (phase == 2);
      repeat (48) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      put_char(loaded_code($urandom_range(0, LOADED_COUNT - 1)));
        else if (pick < 50) put_char(random_nonprintable());
        else if (pick < 60) put_char(NEWLINE_CODE);
        else if (pick < 85) begin
          // mostly real glyph slots, some past the end of the font
          load_row(($urandom_range(0, 9) != 0) ? 7'($urandom_range(0, GLYPHS - 1))
                                               : 7'($urandom_range(GLYPHS, 127)),
                   4'($urandom), 8'($urandom));
        end
        else if (pick < 93) send_other(OP_HOME);
        else                send_other(OP_UNUSED);
      end
    end
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    shadow_cfg           = '0;
    shadow_cfg.ink_color = INK_RESET;
    cursor_col           = '0;
    cursor_row           = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_font_fill();
    test_directed_cases();
    test_config_extremes();
    test_random_traffic();

    wait_idle();
    if (expected_pairs.size() != 0) begin
      mismatch_count++;
      $display("%0d pixel pairs never arrived", expected_pairs.size());
    end
    if (mismatch_count == 0) begin
      $display("text_console_glyph_renderer regression: pass");
    end else begin
      $display("text_console_glyph_renderer regression: fail");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("text_console_glyph_renderer regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hdl/tcgr_pkg.sv
hdl/tcgr_ctrl.sv
hdl/tcgr_dp.sv
hdl/text_console_glyph_renderer.sv
sim/text_console_glyph_renderer_tb.sv
